// ===== rtl/core/nslc_pkg.sv =====
// ----------------------------------------------------------------------------
// nslc_pkg
// Shared widths, codes, word types and the saturation helper for the
// square-law nmos evaluator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nslc_pkg;

  // field widths
  localparam int unsigned VW = 24;          // voltages and Vt, Va
  localparam int unsigned KW = 32;          // process factor
  localparam int unsigned RW = 48;          // result words
  localparam int unsigned IW = 2;           // config register index
  localparam int unsigned CW = 32;          // config write data

  // fixed point shifts
  localparam int unsigned FRAC_V    = 16;   // fraction bits of a voltage
  localparam int unsigned CUR_SHIFT = 25;   // Q64 product, halved, to Q40
  localparam int unsigned G_SHIFT   = 8;    // Q48 product to Q40

  // front datapath widths
  localparam int unsigned OVW = VW + 1;     // overdrive
  localparam int unsigned MXW = VW + 3;     // 2*ov - vds
  localparam int unsigned DVW = VW + 1;     // ov - vds in triode
  localparam int unsigned PW  = MXW + VW;   // voltage product
  localparam int unsigned PLW = 26;         // low slice of the voltage product
  localparam int unsigned PHW = PW - PLW;   // high slice
  localparam int unsigned GPW = KW + 1 + VW;
  localparam int unsigned OPW = KW + DVW;
  localparam int unsigned PPW = KW + 1 + PHW; // partial products of K * p
  localparam int unsigned SW  = KW + PW + 1;  // widest pre-saturation value

  // divider
  localparam int unsigned QW         = RW - 1;
  localparam int unsigned DIV_PER    = 4;
  localparam int unsigned DIV_STAGES = (QW + DIV_PER - 1) / DIV_PER;
  localparam int unsigned DIV_DEPTH  = DIV_STAGES + 1;
  localparam int unsigned CMPW       = VW + QW - FRAC_V;

  // back datapath
  localparam int unsigned HW    = 24;       // split of gm and go
  localparam int unsigned PHIW  = RW - HW + VW;
  localparam int unsigned PLOW  = HW + 1 + VW;
  localparam int unsigned AW    = 74;       // Ieq accumulator at Q56

  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned BACK_STAGES  = 5;

  localparam logic signed [RW-1:0] RES_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] RES_MIN = {1'b1, {(RW-1){1'b0}}};

  // register indexes
  localparam logic [IW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [IW-1:0] CFG_EARLY     = 2'd1;
  localparam logic [IW-1:0] CFG_KFACTOR   = 2'd2;

  localparam logic signed [VW-1:0] VT_RESET = 24'sd32768;
  localparam logic [VW-1:0]        VA_RESET = 24'd655360;
  localparam logic [KW-1:0]        K_RESET  = 32'd4294967;

  typedef enum logic [1:0] {
    REGION_CUTOFF = 2'd0,
    REGION_SAT    = 2'd1,
    REGION_TRIODE = 2'd2
  } region_e;

  typedef struct packed {
    logic signed [VW-1:0] vt;
    logic [VW-1:0]        va;
    logic [KW-1:0]        k;
  } cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] vgs;
    logic signed [VW-1:0] vds;
  } in_t;

  typedef struct packed {
    region_e              region;
    logic signed [VW-1:0] vgs;
    logic signed [VW-1:0] vds;
    logic signed [RW-1:0] cur;
    logic signed [RW-1:0] gm;
    logic signed [RW-1:0] go;
  } front_t;

  typedef struct packed {
    front_t        f;
    logic          ovf;
    logic [VW-1:0] rem;
    logic [QW-1:0] quo;
  } div_t;

  typedef struct packed {
    region_e              region;
    logic signed [RW-1:0] drain_current;
    logic signed [RW-1:0] transconductance;
    logic signed [RW-1:0] output_conductance;
    logic signed [RW-1:0] equivalent_current;
  } res_t;

  // clamp a wide signed value to the result range
  function automatic logic signed [RW-1:0] sat_res(input logic signed [SW-1:0] x);
    logic [SW-RW:0] top;
    top = x[SW-1:RW-1];
    if ((&top) || !(|top)) begin
      return x[RW-1:0];
    end else if (x[SW-1]) begin
      return RES_MIN;
    end else begin
      return RES_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nslc_in_if.sv =====
// ----------------------------------------------------------------------------
// nslc_in_if
// Input channel: one vGS / vDS voltage pair per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nslc_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [nslc_pkg::VW-1:0] gate_source_voltage;
  logic signed [nslc_pkg::VW-1:0] drain_source_voltage;

  modport source (output valid, gate_source_voltage, drain_source_voltage, input ready);
  modport sink   (input valid, gate_source_voltage, drain_source_voltage, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nslc_out_if.sv =====
// ----------------------------------------------------------------------------
// nslc_out_if
// Output channel: current, conductances, equivalent current and region.
// ----------------------------------------------------------------------------
`default_nettype none

interface nslc_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [nslc_pkg::RW-1:0] drain_current;
  logic signed [nslc_pkg::RW-1:0] transconductance;
  logic signed [nslc_pkg::RW-1:0] output_conductance;
  logic signed [nslc_pkg::RW-1:0] equivalent_current;
  logic [1:0]                    region;

  modport source (output valid, drain_current, transconductance, output_conductance,
                  equivalent_current, region, input ready);
  modport sink   (input valid, drain_current, transconductance, output_conductance,
                  equivalent_current, region, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nslc_front.sv =====
// ----------------------------------------------------------------------------
// nslc_front
// Region select, operand products and drain current, gm and triode go in
// five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nslc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nslc_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nslc_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nslc_pkg::front_t  out_data_o
);

  typedef struct packed {
    nslc_pkg::region_e                region;
    logic signed [nslc_pkg::VW-1:0]   vgs;
    logic signed [nslc_pkg::VW-1:0]   vds;
    logic signed [nslc_pkg::MXW-1:0]  mx;
    logic signed [nslc_pkg::VW-1:0]   my;
    logic signed [nslc_pkg::VW-1:0]   g;
    logic [nslc_pkg::DVW-1:0]         dv;
  } s1_t;

  typedef struct packed {
    nslc_pkg::region_e                region;
    logic signed [nslc_pkg::VW-1:0]   vgs;
    logic signed [nslc_pkg::VW-1:0]   vds;
    logic signed [nslc_pkg::PW-1:0]   p;
    logic signed [nslc_pkg::GPW-1:0]  gmp;
    logic [nslc_pkg::OPW-1:0]         gop;
  } s2_t;

  typedef struct packed {
    nslc_pkg::region_e                region;
    logic signed [nslc_pkg::VW-1:0]   vgs;
    logic signed [nslc_pkg::VW-1:0]   vds;
    logic [nslc_pkg::PPW-1:0]         pl;
    logic signed [nslc_pkg::PPW-1:0]  ph;
    logic signed [nslc_pkg::RW-1:0]   gm;
    logic signed [nslc_pkg::RW-1:0]   go;
  } s3_t;

  typedef struct packed {
    nslc_pkg::region_e                region;
    logic signed [nslc_pkg::VW-1:0]   vgs;
    logic signed [nslc_pkg::VW-1:0]   vds;
    logic signed [nslc_pkg::SW-1:0]   kp;
    logic signed [nslc_pkg::RW-1:0]   gm;
    logic signed [nslc_pkg::RW-1:0]   go;
  } s4_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  nslc_pkg::front_t s5_d, s5_q;

  logic [nslc_pkg::FRONT_STAGES-1:0] v_q;
  logic [nslc_pkg::FRONT_STAGES-1:0] v_in;
  logic [nslc_pkg::FRONT_STAGES:0]   en;

  // stage enables ripple back from the consumer
  assign en[nslc_pkg::FRONT_STAGES] = out_ready_i;
  for (genvar i = 0; i < nslc_pkg::FRONT_STAGES; i++) begin : g_en
    assign en[i] = ~v_q[i] | en[i+1];
  end

  assign v_in        = {v_q[nslc_pkg::FRONT_STAGES-2:0], in_valid_i};
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[nslc_pkg::FRONT_STAGES-1];
  assign out_data_o  = s5_q;

  // stage 1: overdrive, region and multiplier operands
  always_comb begin
    logic signed [nslc_pkg::OVW-1:0] ov;
    logic signed [nslc_pkg::MXW-1:0] tm;
    logic [nslc_pkg::DVW-1:0]        dv;
    logic                            cutoff;
    logic                            sat;
    ov     = {in_data_i.vgs[nslc_pkg::VW-1], in_data_i.vgs}
           - {cfg_i.vt[nslc_pkg::VW-1], cfg_i.vt};
    cutoff = ov[nslc_pkg::OVW-1];
    sat    = ~cutoff & (ov < $signed({in_data_i.vds[nslc_pkg::VW-1], in_data_i.vds}));
    tm     = {ov[nslc_pkg::OVW-1], ov, 1'b0}
           - {{(nslc_pkg::MXW-nslc_pkg::VW){in_data_i.vds[nslc_pkg::VW-1]}}, in_data_i.vds};
    dv     = ov - $signed({in_data_i.vds[nslc_pkg::VW-1], in_data_i.vds});
    s1_d.vgs = in_data_i.vgs;
    s1_d.vds = in_data_i.vds;
    if (cutoff) begin
      s1_d.region = nslc_pkg::REGION_CUTOFF;
      s1_d.mx     = '0;
      s1_d.my     = '0;
      s1_d.g      = '0;
      s1_d.dv     = '0;
    end else if (sat) begin
      s1_d.region = nslc_pkg::REGION_SAT;
      s1_d.mx     = {2'b00, ov};
      s1_d.my     = ov[nslc_pkg::VW-1:0];
      s1_d.g      = ov[nslc_pkg::VW-1:0];
      s1_d.dv     = '0;
    end else begin
      s1_d.region = nslc_pkg::REGION_TRIODE;
      s1_d.mx     = tm;
      s1_d.my     = in_data_i.vds;
      s1_d.g      = in_data_i.vds;
      s1_d.dv     = dv;
    end
  end

  // stage 2: voltage product and the K products for gm and go
  always_comb begin
    s2_d.region = s1_q.region;
    s2_d.vgs    = s1_q.vgs;
    s2_d.vds    = s1_q.vds;
    s2_d.p      = s1_q.mx * s1_q.my;
    s2_d.gmp    = $signed({1'b0, cfg_i.k}) * s1_q.g;
    s2_d.gop    = cfg_i.k * s1_q.dv;
  end

  // stage 3: K times the voltage product in two slices, gm and go clamp
  always_comb begin
    s3_d.region = s2_q.region;
    s3_d.vgs    = s2_q.vgs;
    s3_d.vds    = s2_q.vds;
    s3_d.pl     = cfg_i.k * s2_q.p[nslc_pkg::PLW-1:0];
    s3_d.ph     = $signed({1'b0, cfg_i.k}) * $signed(s2_q.p[nslc_pkg::PW-1:nslc_pkg::PLW]);
    s3_d.gm     = nslc_pkg::sat_res(nslc_pkg::SW'(s2_q.gmp >>> nslc_pkg::G_SHIFT));
    s3_d.go     = nslc_pkg::sat_res(nslc_pkg::SW'(s2_q.gop >> nslc_pkg::G_SHIFT));
  end

  // stage 4: combine the slices
  always_comb begin
    s4_d.region = s3_q.region;
    s4_d.vgs    = s3_q.vgs;
    s4_d.vds    = s3_q.vds;
    s4_d.gm     = s3_q.gm;
    s4_d.go     = s3_q.go;
    s4_d.kp     = (nslc_pkg::SW'(s3_q.ph) <<< nslc_pkg::PLW) + nslc_pkg::SW'(s3_q.pl);
  end

  // stage 5: drain current to Q40 with clamp
  always_comb begin
    s5_d.region = s4_q.region;
    s5_d.vgs    = s4_q.vgs;
    s5_d.vds    = s4_q.vds;
    s5_d.gm     = s4_q.gm;
    s5_d.go     = s4_q.go;
    s5_d.cur    = nslc_pkg::sat_res(s4_q.kp >>> nslc_pkg::CUR_SHIFT);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < nslc_pkg::FRONT_STAGES; i++) begin
        if (en[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
    if (en[3]) s4_q <= s4_d;
    if (en[4]) s5_q <= s5_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/nslc_div.sv =====
// ----------------------------------------------------------------------------
// nslc_div
// Pipelined restoring divider for the saturation output conductance
// I * 2^16 / Va, four quotient bits per stage, with overflow detect.
// ----------------------------------------------------------------------------
`default_nettype none

module nslc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nslc_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nslc_pkg::front_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nslc_pkg::div_t    out_data_o
);

  nslc_pkg::div_t stage_d [nslc_pkg::DIV_DEPTH];
  nslc_pkg::div_t stage_q [nslc_pkg::DIV_DEPTH];

  logic [nslc_pkg::DIV_DEPTH-1:0] v_q;
  logic [nslc_pkg::DIV_DEPTH-1:0] v_in;
  logic [nslc_pkg::DIV_DEPTH:0]   en;

  assign en[nslc_pkg::DIV_DEPTH] = out_ready_i;
  for (genvar i = 0; i < nslc_pkg::DIV_DEPTH; i++) begin : g_en
    assign en[i] = ~v_q[i] | en[i+1];
  end

  assign v_in        = {v_q[nslc_pkg::DIV_DEPTH-2:0], in_valid_i};
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[nslc_pkg::DIV_DEPTH-1];
  assign out_data_o  = stage_q[nslc_pkg::DIV_DEPTH-1];

  // first stage: quotient overflow check and the leading remainder
  always_comb begin
    stage_d[0].f   = in_data_i;
    stage_d[0].ovf = nslc_pkg::CMPW'(in_data_i.cur[nslc_pkg::QW-1:0])
                     >= {cfg_i.va, {(nslc_pkg::QW-nslc_pkg::FRAC_V){1'b0}}};
    stage_d[0].rem = nslc_pkg::VW'(
                       in_data_i.cur[nslc_pkg::QW-1:nslc_pkg::QW-nslc_pkg::FRAC_V]);
    stage_d[0].quo = '0;
  end

  // long division steps, four quotient bits per stage, one per step
  for (genvar k = 1; k < nslc_pkg::DIV_DEPTH; k++) begin : g_step
    always_comb begin
      nslc_pkg::div_t           s;
      logic [nslc_pkg::QW-1:0]  dvd;
      logic [nslc_pkg::VW:0]    trial;
      int                       bidx;
      s     = stage_q[k-1];
      dvd   = {s.f.cur[nslc_pkg::QW-nslc_pkg::FRAC_V-1:0], {nslc_pkg::FRAC_V{1'b0}}};
      trial = '0;
      for (int j = 0; j < nslc_pkg::DIV_PER; j++) begin
        bidx = (k - 1) * nslc_pkg::DIV_PER + j;
        if (bidx < nslc_pkg::QW) begin
          trial = {s.rem, dvd[nslc_pkg::QW-1-bidx]};
          if (trial >= {1'b0, cfg_i.va}) begin
            s.rem = nslc_pkg::VW'(trial - {1'b0, cfg_i.va});
            s.quo = {s.quo[nslc_pkg::QW-2:0], 1'b1};
          end else begin
            s.rem = trial[nslc_pkg::VW-1:0];
            s.quo = {s.quo[nslc_pkg::QW-2:0], 1'b0};
          end
        end
      end
      stage_d[k] = s;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < nslc_pkg::DIV_DEPTH; i++) begin
        if (en[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < nslc_pkg::DIV_DEPTH; i++) begin
      if (en[i]) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nslc_back.sv =====
// ----------------------------------------------------------------------------
// nslc_back
// Output conductance select and the linearized current Ieq in five
// register stages; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nslc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nslc_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nslc_pkg::div_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nslc_pkg::res_t   out_data_o
);

  typedef struct packed {
    nslc_pkg::region_e               region;
    logic signed [nslc_pkg::VW-1:0]  vgs;
    logic signed [nslc_pkg::VW-1:0]  vds;
    logic signed [nslc_pkg::RW-1:0]  cur;
    logic signed [nslc_pkg::RW-1:0]  gm;
    logic signed [nslc_pkg::RW-1:0]  go;
  } b1_t;

  typedef struct packed {
    nslc_pkg::region_e                 region;
    logic signed [nslc_pkg::RW-1:0]    cur;
    logic signed [nslc_pkg::RW-1:0]    gm;
    logic signed [nslc_pkg::RW-1:0]    go;
    logic signed [nslc_pkg::PHIW-1:0]  pgh;
    logic signed [nslc_pkg::PLOW-1:0]  pgl;
    logic signed [nslc_pkg::PHIW-1:0]  poh;
    logic signed [nslc_pkg::PLOW-1:0]  pol;
  } b2_t;

  typedef struct packed {
    nslc_pkg::region_e               region;
    logic signed [nslc_pkg::RW-1:0]  cur;
    logic signed [nslc_pkg::RW-1:0]  gm;
    logic signed [nslc_pkg::RW-1:0]  go;
    logic signed [nslc_pkg::AW-1:0]  pg;
    logic signed [nslc_pkg::AW-1:0]  po;
  } b3_t;

  typedef struct packed {
    nslc_pkg::region_e               region;
    logic signed [nslc_pkg::RW-1:0]  cur;
    logic signed [nslc_pkg::RW-1:0]  gm;
    logic signed [nslc_pkg::RW-1:0]  go;
    logic signed [nslc_pkg::AW-1:0]  acc;
  } b4_t;

  b1_t b1_d, b1_q;
  b2_t b2_d, b2_q;
  b3_t b3_d, b3_q;
  b4_t b4_d, b4_q;
  nslc_pkg::res_t b5_d, b5_q;

  logic [nslc_pkg::BACK_STAGES-1:0] v_q;
  logic [nslc_pkg::BACK_STAGES-1:0] v_in;
  logic [nslc_pkg::BACK_STAGES:0]   en;

  assign en[nslc_pkg::BACK_STAGES] = out_ready_i;
  for (genvar i = 0; i < nslc_pkg::BACK_STAGES; i++) begin : g_en
    assign en[i] = ~v_q[i] | en[i+1];
  end

  assign v_in        = {v_q[nslc_pkg::BACK_STAGES-2:0], in_valid_i};
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[nslc_pkg::BACK_STAGES-1];
  assign out_data_o  = b5_q;

  // stage 1: pick go, saturation uses the quotient
  always_comb begin
    b1_d.region = in_data_i.f.region;
    b1_d.vgs    = in_data_i.f.vgs;
    b1_d.vds    = in_data_i.f.vds;
    b1_d.cur    = in_data_i.f.cur;
    b1_d.gm     = in_data_i.f.gm;
    if (in_data_i.f.region == nslc_pkg::REGION_SAT) begin
      if (cfg_i.va == '0) begin
        // zero early voltage: full scale unless there is no current
        b1_d.go = (in_data_i.f.cur != '0) ? nslc_pkg::RES_MAX : '0;
      end else if (in_data_i.ovf) begin
        b1_d.go = nslc_pkg::RES_MAX;
      end else begin
        b1_d.go = {1'b0, in_data_i.quo};
      end
    end else begin
      b1_d.go = in_data_i.f.go;
    end
  end

  // stage 2: gm*vGS and go*vDS as split partial products
  always_comb begin
    b2_d.region = b1_q.region;
    b2_d.cur    = b1_q.cur;
    b2_d.gm     = b1_q.gm;
    b2_d.go     = b1_q.go;
    b2_d.pgh    = $signed(b1_q.gm[nslc_pkg::RW-1:nslc_pkg::HW]) * b1_q.vgs;
    b2_d.pgl    = $signed({1'b0, b1_q.gm[nslc_pkg::HW-1:0]}) * b1_q.vgs;
    b2_d.poh    = $signed(b1_q.go[nslc_pkg::RW-1:nslc_pkg::HW]) * b1_q.vds;
    b2_d.pol    = $signed({1'b0, b1_q.go[nslc_pkg::HW-1:0]}) * b1_q.vds;
  end

  // stage 3: merge the partial products
  always_comb begin
    b3_d.region = b2_q.region;
    b3_d.cur    = b2_q.cur;
    b3_d.gm     = b2_q.gm;
    b3_d.go     = b2_q.go;
    b3_d.pg     = (nslc_pkg::AW'(b2_q.pgh) <<< nslc_pkg::HW) + nslc_pkg::AW'(b2_q.pgl);
    b3_d.po     = (nslc_pkg::AW'(b2_q.poh) <<< nslc_pkg::HW) + nslc_pkg::AW'(b2_q.pol);
  end

  // stage 4: Ieq accumulator at Q56
  always_comb begin
    b4_d.region = b3_q.region;
    b4_d.cur    = b3_q.cur;
    b4_d.gm     = b3_q.gm;
    b4_d.go     = b3_q.go;
    b4_d.acc    = (nslc_pkg::AW'(b3_q.cur) <<< nslc_pkg::FRAC_V) - b3_q.pg - b3_q.po;
  end

  // stage 5: floor to Q40, clamp, output word
  always_comb begin
    b5_d.region             = b4_q.region;
    b5_d.drain_current      = b4_q.cur;
    b5_d.transconductance   = b4_q.gm;
    b5_d.output_conductance = b4_q.go;
    b5_d.equivalent_current =
      nslc_pkg::sat_res(nslc_pkg::SW'(b4_q.acc >>> nslc_pkg::FRAC_V));
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < nslc_pkg::BACK_STAGES; i++) begin
        if (en[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) b1_q <= b1_d;
    if (en[1]) b2_q <= b2_d;
    if (en[2]) b3_q <= b3_d;
    if (en[3]) b4_q <= b4_d;
    if (en[4]) b5_q <= b5_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/nmos_square_law_companion.sv =====
// ----------------------------------------------------------------------------
// nmos_square_law_companion
// Throughput: one word per cycle; the 13-stage divider for saturation go
// sets the pipeline depth, and every stage holds its word on a stall.
// Reset clears all valid bits and loads Vt = 0.5 V, Va = 10 V, K ~ 1e-3.
// ----------------------------------------------------------------------------
`default_nettype none

module nmos_square_law_companion (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nslc_pkg::IW-1:0]    cfg_idx_i,
  input  logic [nslc_pkg::CW-1:0]    cfg_data_i,
  nslc_in_if.sink                    in_i,
  nslc_out_if.source                 out_o
);

  nslc_pkg::cfg_t   cfg_q;
  nslc_pkg::in_t    in_data;
  nslc_pkg::front_t front_data;
  nslc_pkg::div_t   div_data;
  nslc_pkg::res_t   res_data;

  logic front_valid, front_ready;
  logic div_valid, div_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vt <= nslc_pkg::VT_RESET;
      cfg_q.va <= nslc_pkg::VA_RESET;
      cfg_q.k  <= nslc_pkg::K_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nslc_pkg::CFG_THRESHOLD: cfg_q.vt <= cfg_data_i[nslc_pkg::VW-1:0];
        nslc_pkg::CFG_EARLY:     cfg_q.va <= cfg_data_i[nslc_pkg::VW-1:0];
        nslc_pkg::CFG_KFACTOR:   cfg_q.k  <= cfg_data_i[nslc_pkg::KW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_data.vgs = in_i.gate_source_voltage;
  assign in_data.vds = in_i.drain_source_voltage;

  nslc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_data),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  nslc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  nslc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_data_i   (div_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_data)
  );

  // result word onto the output channel
  assign out_o.drain_current      = res_data.drain_current;
  assign out_o.transconductance   = res_data.transconductance;
  assign out_o.output_conductance = res_data.output_conductance;
  assign out_o.equivalent_current = res_data.equivalent_current;
  assign out_o.region             = res_data.region;

endmodule

`default_nettype wire
